FILE: src/bbm_pkg.sv
// bbm_pkg: constants, field widths and the controller-to-datapath command
// struct shared by the binary block matching motion search files
// no dependencies
package bbm_pkg;

  localparam int FRAME_SIZE = 128;
  localparam int BLOCK_SIZE = 8;
  localparam int NBLOCKS    = FRAME_SIZE / BLOCK_SIZE;
  localparam int NPIX       = FRAME_SIZE * FRAME_SIZE;
  localparam int NWORDS     = FRAME_SIZE * NBLOCKS;
  localparam int AW         = $clog2(NWORDS);
  localparam int KW         = (BLOCK_SIZE > 2) ? $clog2(BLOCK_SIZE) : 1;
  localparam int COST_W     = $clog2(BLOCK_SIZE * BLOCK_SIZE + 1);
  localparam int POP_W      = $clog2(BLOCK_SIZE + 1);

  localparam int IDX_W  = 14;
  localparam int BIDX_W = 4;
  localparam int RAD_W  = 4;
  localparam int BB_W   = 8;
  localparam int DIST_W = 7;
  localparam int ROW_W  = 3;
  localparam int DIFF_W = 16;

  localparam int DIST_MAX = (1 << DIST_W) - 1;
  localparam logic [RAD_W-1:0] RAD_RESET = RAD_W'(1);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_MATCH = 1'b1;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic              use_best;
    logic              first_cand;
    logic              row_last;
    logic              out_load;
    logic [BIDX_W-1:0] tgt_r;
    logic [BIDX_W-1:0] tgt_c;
    logic [BIDX_W-1:0] cand_r;
    logic [BIDX_W-1:0] cand_c;
    logic [KW-1:0]     row;
  } cmd_t;

endpackage

FILE: src/bbm_datapath.sv
// bbm_datapath: row-wide frame memories, Hamming cost accumulator, best
// candidate registers and the result output register
// depends on bbm_pkg
module bbm_datapath import bbm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic [IDX_W-1:0]  in_pixel_index,
  input  logic              in_cur_pixel,
  input  logic              in_prev_pixel,
  output logic [BB_W-1:0]   out_best_block,
  output logic [DIST_W-1:0] out_best_distance,
  output logic [ROW_W-1:0]  out_row_in_block,
  output logic [DIFF_W-1:0] out_row_diffs,
  output logic              out_last
);

  logic [BLOCK_SIZE-1:0] cur_mem  [NWORDS];
  logic [BLOCK_SIZE-1:0] prev_mem [NWORDS];

  logic [BLOCK_SIZE-1:0] cur_q_r, prev_q_r;
  logic                  s_valid_r;
  logic                  s_row0_r, s_last_r, s_first_r;
  logic [BIDX_W-1:0]     s_cr_r, s_cc_r;
  logic [COST_W-1:0]     acc_r, acc_sum;
  logic [COST_W-1:0]     best_d_r;
  logic [BIDX_W-1:0]     best_r_r, best_c_r;
  logic [POP_W-1:0]      pop;

  logic [31:0]           widx;
  logic                  wr_ok;
  logic [AW-1:0]         waddr, raddr_c, raddr_p;
  logic [KW-1:0]         wbit;
  logic [BIDX_W-1:0]     pr, pc;
  logic [BB_W-1:0]       lin;
  logic [DIFF_W-1:0]     diffs;

  logic [BB_W-1:0]       out_best_block_r;
  logic [DIST_W-1:0]     out_best_distance_r;
  logic [ROW_W-1:0]      out_row_in_block_r;
  logic [DIFF_W-1:0]     out_row_diffs_r;
  logic                  out_last_r;

  function automatic logic [AW-1:0] row_addr(logic [BIDX_W-1:0] b_r, logic [BIDX_W-1:0] b_c,
                                             logic [KW-1:0] k);
    return AW'((32'(b_r) * BLOCK_SIZE + 32'(k)) * NBLOCKS + 32'(b_c));
  endfunction

  // pixel load addressing
  assign widx  = 32'(in_pixel_index);
  assign wr_ok = widx < NPIX;
  assign waddr = AW'((widx / FRAME_SIZE) * NBLOCKS + (widx % FRAME_SIZE) / BLOCK_SIZE);
  assign wbit  = KW'(widx % BLOCK_SIZE);

  assign pr      = cmd.use_best ? best_r_r : cmd.cand_r;
  assign pc      = cmd.use_best ? best_c_r : cmd.cand_c;
  assign raddr_c = row_addr(cmd.tgt_r, cmd.tgt_c, cmd.row);
  assign raddr_p = row_addr(pr, pc, cmd.row);

  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_ok) begin
      cur_mem[waddr][wbit]  <= in_cur_pixel;
      prev_mem[waddr][wbit] <= in_prev_pixel;
    end
    if (cmd.rd_en) begin
      cur_q_r  <= cur_mem[raddr_c];
      prev_q_r <= prev_mem[raddr_p];
    end
  end

  // cost accumulation, one block row per cycle
  assign pop     = POP_W'($countones(cur_q_r ^ prev_q_r));
  assign acc_sum = (s_row0_r ? COST_W'(0) : acc_r) + COST_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      s_valid_r <= cmd.rd_en && !cmd.use_best;
    end
    s_row0_r  <= cmd.row == KW'(0);
    s_last_r  <= cmd.row_last;
    s_first_r <= cmd.first_cand;
    s_cr_r    <= cmd.cand_r;
    s_cc_r    <= cmd.cand_c;
    if (s_valid_r) begin
      acc_r <= acc_sum;
      if (s_last_r && (s_first_r || acc_sum < best_d_r)) begin
        best_d_r <= acc_sum;
        best_r_r <= s_cr_r;
        best_c_r <= s_cc_r;
      end
    end
  end

  // result row
  assign lin = BB_W'(32'(best_r_r) * NBLOCKS + 32'(best_c_r));

  always_comb begin
    diffs = '0;
    for (int l = 0; l < BLOCK_SIZE; l++) begin
      if (2 * l + 1 < DIFF_W) begin
        if (cur_q_r[l] != prev_q_r[l]) begin
          diffs[2*l +: 2] = cur_q_r[l] ? 2'b01 : 2'b11;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_best_block_r    <= lin;
      out_best_distance_r <= (32'(best_d_r) > DIST_MAX) ? DIST_W'(DIST_MAX)
                                                       : DIST_W'(best_d_r);
      out_row_in_block_r  <= ROW_W'(cmd.row);
      out_row_diffs_r     <= diffs;
      out_last_r          <= cmd.row_last;
    end
  end

  assign out_best_block    = out_best_block_r;
  assign out_best_distance = out_best_distance_r;
  assign out_row_in_block  = out_row_in_block_r;
  assign out_row_diffs     = out_row_diffs_r;
  assign out_last          = out_last_r;

endmodule

FILE: src/bbm_ctrl.sv
// bbm_ctrl: match sequencer state machine, search window bounds, candidate
// scan and the search radius register
// depends on bbm_pkg
module bbm_ctrl import bbm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_command,
  input  logic [BIDX_W-1:0] in_block_row,
  input  logic [BIDX_W-1:0] in_block_col,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              cfg_we,
  input  logic [RAD_W-1:0]  cfg_wdata,
  output cmd_t              cmd
);

  typedef enum logic [2:0] {IDLE, COST, DRAIN, ORD, OLD, OWAIT} state_t;

  typedef struct packed {
    logic              done;
    logic [BIDX_W-1:0] r;
    logic [BIDX_W-1:0] c;
  } pos_t;

  localparam logic [BIDX_W-1:0] BMAX = BIDX_W'(NBLOCKS - 1);
  localparam logic [KW-1:0]     KLAST = KW'(BLOCK_SIZE - 1);

  state_t            state_r;
  logic              out_valid_r;
  logic [RAD_W-1:0]  radius_r;
  logic [KW-1:0]     k_r;
  logic              first_r;
  logic [BIDX_W-1:0] tgt_r_r, tgt_c_r, cr_r, cc_r;
  logic [BIDX_W-1:0] lo_c_r, hi_r_r, hi_c_r, lo_r_r;

  logic              in_acc, match_go, k_last;
  logic [BIDX_W-1:0] lo_r_nxt, hi_r_nxt, lo_c_nxt, hi_c_nxt;
  pos_t              step_a, step_b, start;

  function automatic pos_t adv(pos_t p, logic [BIDX_W-1:0] lo_c, logic [BIDX_W-1:0] hi_r,
                               logic [BIDX_W-1:0] hi_c);
    pos_t q;
    q      = p;
    q.done = 1'b0;
    if (p.c == hi_c) begin
      if (p.r == hi_r) begin
        q.done = 1'b1;
      end else begin
        q.r = p.r + 1'b1;
        q.c = lo_c;
      end
    end else begin
      q.c = p.c + 1'b1;
    end
    return q;
  endfunction

  function automatic logic [BIDX_W-1:0] win_lo(logic [BIDX_W-1:0] b, logic [RAD_W-1:0] rad);
    return (BIDX_W'(b) > BIDX_W'(rad)) ? b - BIDX_W'(rad) : BIDX_W'(0);
  endfunction

  function automatic logic [BIDX_W-1:0] win_hi(logic [BIDX_W-1:0] b, logic [RAD_W-1:0] rad);
    logic [BIDX_W:0] s;
    s = {1'b0, b} + (BIDX_W + 1)'(rad);
    return (s > {1'b0, BMAX}) ? BMAX : s[BIDX_W-1:0];
  endfunction

  assign in_ready  = state_r == IDLE;
  assign out_valid = out_valid_r;
  assign in_acc    = in_valid && in_ready;
  assign match_go  = in_acc && in_command == CMD_MATCH &&
                     32'(in_block_row) < NBLOCKS && 32'(in_block_col) < NBLOCKS;
  assign k_last    = k_r == KLAST;

  assign lo_r_nxt = win_lo(in_block_row, radius_r);
  assign hi_r_nxt = win_hi(in_block_row, radius_r);
  assign lo_c_nxt = win_lo(in_block_col, radius_r);
  assign hi_c_nxt = win_hi(in_block_col, radius_r);

  // next candidate in scan order, skipping the co-located block
  assign start  = '{done: 1'b0, r: lo_r_r, c: lo_c_r};
  assign step_a = first_r ? start : adv('{done: 1'b0, r: cr_r, c: cc_r}, lo_c_r, hi_r_r, hi_c_r);
  assign step_b = (!step_a.done && step_a.r == tgt_r_r && step_a.c == tgt_c_r)
                  ? adv(step_a, lo_c_r, hi_r_r, hi_c_r) : step_a;

  always_comb begin
    cmd            = '0;
    cmd.tgt_r      = tgt_r_r;
    cmd.tgt_c      = tgt_c_r;
    cmd.cand_r     = cr_r;
    cmd.cand_c     = cc_r;
    cmd.row        = k_r;
    cmd.first_cand = first_r;
    cmd.row_last   = k_last;
    unique case (state_r)
      IDLE: begin
        cmd.wr_en = in_acc && in_command == CMD_LOAD;
      end
      COST: begin
        cmd.rd_en = 1'b1;
      end
      DRAIN: begin
      end
      ORD: begin
        cmd.rd_en    = 1'b1;
        cmd.use_best = 1'b1;
      end
      OLD: begin
        cmd.out_load = 1'b1;
      end
      OWAIT: begin
        cmd.rd_en    = out_ready && !k_last;
        cmd.use_best = 1'b1;
        cmd.row      = k_r + 1'b1;
        cmd.row_last = (k_r + 1'b1) == KLAST;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
      radius_r    <= RAD_RESET;
    end else begin
      if (cfg_we) begin
        radius_r <= cfg_wdata;
      end
      unique case (state_r)
        IDLE: begin
          if (match_go) begin
            tgt_r_r <= in_block_row;
            tgt_c_r <= in_block_col;
            cr_r    <= in_block_row;
            cc_r    <= in_block_col;
            lo_r_r  <= lo_r_nxt;
            hi_r_r  <= hi_r_nxt;
            lo_c_r  <= lo_c_nxt;
            hi_c_r  <= hi_c_nxt;
            first_r <= 1'b1;
            k_r     <= '0;
            state_r <= COST;
          end
        end
        COST: begin
          if (k_last) begin
            k_r     <= '0;
            first_r <= 1'b0;
            cr_r    <= step_b.r;
            cc_r    <= step_b.c;
            state_r <= step_b.done ? DRAIN : COST;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        DRAIN: begin
          state_r <= ORD;
        end
        ORD: begin
          state_r <= OLD;
        end
        OLD: begin
          out_valid_r <= 1'b1;
          state_r     <= OWAIT;
        end
        OWAIT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (k_last) begin
              state_r <= IDLE;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= OLD;
            end
          end
        end
        default: begin
          state_r <= IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/binary_block_matching_motion_search.sv
// binary_block_matching_motion_search: top level, joins the match sequencer
// and the frame memory datapath
// depends on bbm_pkg, bbm_ctrl, bbm_datapath
//
// input channel (in_valid/in_ready): command 0 stores one pixel pair at
// in_pixel_index in both frames and gives no result.
// command 1 matches the block at in_block_row/in_block_col; a target
// outside the frame gives no result. a match compares the co-located
// block and every other in-frame candidate within search_radius blocks,
// reading one block row per cycle from each row-wide frame memory.
// the result channel (out_valid/out_ready) then carries 8 transactions,
// one per block row; out_last marks the final row. a stalled receiver
// holds the row in the output register and the sequencer waits. no
// input is taken until the last row transaction completes.
// cfg_we/cfg_wdata set search_radius, reset value 1, written while idle.
// synchronous reset returns to idle with no pending result; frame
// contents are undefined until loaded.
module binary_block_matching_motion_search import bbm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_command,
  input  logic [IDX_W-1:0]  in_pixel_index,
  input  logic              in_cur_pixel,
  input  logic              in_prev_pixel,
  input  logic [BIDX_W-1:0] in_block_row,
  input  logic [BIDX_W-1:0] in_block_col,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BB_W-1:0]   out_best_block,
  output logic [DIST_W-1:0] out_best_distance,
  output logic [ROW_W-1:0]  out_row_in_block,
  output logic [DIFF_W-1:0] out_row_diffs,
  output logic              out_last,
  input  logic              cfg_we,
  input  logic [RAD_W-1:0]  cfg_wdata
);

  cmd_t cmd;

  bbm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_block_row (in_block_row),
    .in_block_col (in_block_col),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd)
  );

  bbm_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_pixel_index    (in_pixel_index),
    .in_cur_pixel      (in_cur_pixel),
    .in_prev_pixel     (in_prev_pixel),
    .out_best_block    (out_best_block),
    .out_best_distance (out_best_distance),
    .out_row_in_block  (out_row_in_block),
    .out_row_diffs     (out_row_diffs),
    .out_last          (out_last)
  );

endmodule

FILE: src/bbm_checker.sv
// bbm_checker: port-level assertions for the motion search top level,
// attached by the bind statement at the end of this file
// depends on bbm_pkg, binary_block_matching_motion_search
module bbm_checker import bbm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BB_W-1:0]   out_best_block,
  input logic [DIST_W-1:0] out_best_distance,
  input logic [ROW_W-1:0]  out_row_in_block,
  input logic [DIFF_W-1:0] out_row_diffs,
  input logic              out_last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_best_block) &&
      $stable(out_best_distance) && $stable(out_row_in_block) &&
      $stable(out_row_diffs) && $stable(out_last))
    else $error("result changed while stalled");

  // no input transaction while a result is pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready with result pending");

  // a match stays busy until its final row
  a_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> !in_ready)
    else $error("input ready before final row");

  // final row carries the last row index
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_row_in_block == ROW_W'(BLOCK_SIZE - 1))
    else $error("final row index mismatch");

  // reset clears pending results
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind binary_block_matching_motion_search bbm_checker u_bbm_checker (.*);

FILE: verif/binary_block_matching_motion_search_test.sv
`timescale 1ns / 100ps
// testbench for binary_block_matching_motion_search: fills a corner region of both
// frames, then runs directed and random load/match traffic under several search radii
// depends on bbm_pkg and the binary_block_matching_motion_search top level
module binary_block_matching_motion_search_test;
  import bbm_pkg::*;

  localparam int FILL_BLOCKS = 2;
  localparam int FILL_PIX    = FILL_BLOCKS * BLOCK_SIZE;

  typedef struct packed {
    logic              command;
    logic [IDX_W-1:0]  pixel_index;
    logic              cur_pixel;
    logic              prev_pixel;
    logic [BIDX_W-1:0] block_row;
    logic [BIDX_W-1:0] block_col;
  } request_t;

  typedef struct packed {
    logic [BB_W-1:0]   best_block;
    logic [DIST_W-1:0] best_distance;
    logic [ROW_W-1:0]  row_in_block;
    logic [DIFF_W-1:0] row_diffs;
    logic              last;
  } row_result_t;

  class match_scoreboard;
    bit cur_frame [NPIX];
    bit prev_frame [NPIX];
    logic [RAD_W-1:0] radius;
    row_result_t expected_rows [$];
    int errors;

    function new();
      radius = RAD_RESET;
      errors = 0;
    endfunction

    function int hamming(int tr, int tc, int cr, int cc);
      int sum;
      int t_base;
      int c_base;
      sum = 0;
      t_base = tr * BLOCK_SIZE * FRAME_SIZE + tc * BLOCK_SIZE;
      c_base = cr * BLOCK_SIZE * FRAME_SIZE + cc * BLOCK_SIZE;
      for (int k = 0; k < BLOCK_SIZE; k++) begin
        for (int l = 0; l < BLOCK_SIZE; l++) begin
          sum += cur_frame[t_base + k * FRAME_SIZE + l] ^ prev_frame[c_base + k * FRAME_SIZE + l];
        end
      end
      return sum;
    endfunction

    function void accept_request(request_t req);
      int best_r;
      int best_c;
      int best_d;
      int d;
      int cr;
      int cc;
      int rad;
      int t_base;
      int c_base;
      bit c;
      bit p;
      row_result_t row;
      if (req.command == CMD_LOAD) begin
        cur_frame[req.pixel_index] = req.cur_pixel;
        prev_frame[req.pixel_index] = req.prev_pixel;
        return;
      end
      best_r = int'(req.block_row);
      best_c = int'(req.block_col);
      best_d = hamming(best_r, best_c, best_r, best_c);
      rad = int'(radius);
      for (int dx = -rad; dx <= rad; dx++) begin
        cr = int'(req.block_row) + dx;
        if (cr < 0 || cr >= NBLOCKS) continue;
        for (int dy = -rad; dy <= rad; dy++) begin
          cc = int'(req.block_col) + dy;
          if (cc < 0 || cc >= NBLOCKS) continue;
          d = hamming(int'(req.block_row), int'(req.block_col), cr, cc);
          if (d < best_d) begin
            best_d = d;
            best_r = cr;
            best_c = cc;
          end
        end
      end
      t_base = int'(req.block_row) * BLOCK_SIZE * FRAME_SIZE + int'(req.block_col) * BLOCK_SIZE;
      c_base = best_r * BLOCK_SIZE * FRAME_SIZE + best_c * BLOCK_SIZE;
      for (int k = 0; k < BLOCK_SIZE; k++) begin
        row.best_block = BB_W'(best_r * NBLOCKS + best_c);
        row.best_distance = (best_d > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(best_d);
        row.row_in_block = ROW_W'(k);
        row.row_diffs = '0;
        for (int l = 0; l < BLOCK_SIZE; l++) begin
          c = cur_frame[t_base + k * FRAME_SIZE + l];
          p = prev_frame[c_base + k * FRAME_SIZE + l];
          row.row_diffs[2 * l +: 2] = {p & ~c, c ^ p};
        end
        row.last = (k == BLOCK_SIZE - 1);
        expected_rows.push_back(row);
      end
    endfunction

    function void check_row(row_result_t got);
      row_result_t want;
      if (expected_rows.size() == 0) begin
        errors++;
        $display("%0t: unexpected row transaction, expected none", $time);
        $display("%0t:   got block %0d dist %0d row %0d diffs %h last %0d", $time,
                 got.best_block, got.best_distance, got.row_in_block, got.row_diffs,
                 got.last);
        return;
      end
      want = expected_rows.pop_front();
      if (got.best_block !== want.best_block) begin
        errors++;
        $display("%0t: best_block expected %0d got %0d", $time, want.best_block, got.best_block);
      end
      if (got.best_distance !== want.best_distance) begin
        errors++;
        $display("%0t: best_distance expected %0d got %0d", $time, want.best_distance,
                 got.best_distance);
      end
      if (got.row_in_block !== want.row_in_block) begin
        errors++;
        $display("%0t: row_in_block expected %0d got %0d", $time, want.row_in_block,
                 got.row_in_block);
      end
      if (got.row_diffs !== want.row_diffs) begin
        errors++;
        $display("%0t: row_diffs expected %h got %h", $time, want.row_diffs, got.row_diffs);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last expected %0d got %0d", $time, want.last, got.last);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_command;
  logic [IDX_W-1:0]  in_pixel_index;
  logic              in_cur_pixel;
  logic              in_prev_pixel;
  logic [BIDX_W-1:0] in_block_row;
  logic [BIDX_W-1:0] in_block_col;
  logic              out_valid;
  logic              out_ready;
  logic [BB_W-1:0]   out_best_block;
  logic [DIST_W-1:0] out_best_distance;
  logic [ROW_W-1:0]  out_row_in_block;
  logic [DIFF_W-1:0] out_row_diffs;
  logic              out_last;
  logic              cfg_we;
  logic [RAD_W-1:0]  cfg_wdata;

  match_scoreboard sb;
  int burst_left;
  int max_gap;
  int rows_seen = 0;

  binary_block_matching_motion_search dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_pixel_index    (in_pixel_index),
    .in_cur_pixel      (in_cur_pixel),
    .in_prev_pixel     (in_prev_pixel),
    .in_block_row      (in_block_row),
    .in_block_col      (in_block_col),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_best_block    (out_best_block),
    .out_best_distance (out_best_distance),
    .out_row_in_block  (out_row_in_block),
    .out_row_diffs     (out_row_diffs),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_row({out_best_block, out_best_distance, out_row_in_block, out_row_diffs,
                    out_last});
      rows_seen++;
    end
  end

  // receiver: changing stall modes plus one long hold-off to back up the input
  initial begin : receiver
    int mode;
    int mode_left;
    int hold_left;
    int tick;
    bit hold_used;
    out_ready = 1'b0;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    tick = 0;
    hold_used = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_used && rows_seen >= 32) begin
        hold_used = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 80);
        end
        mode_left--;
        tick++;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= (tick % 4 == 0);
        endcase
      end
    end
  end

  initial begin
    #(1_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  // block index whose whole search window stays inside the filled region
  function automatic int pick_block(int rad);
    return int'($urandom_range(0, FILL_BLOCKS - 1 - rad));
  endfunction

  task automatic send_item(input request_t req);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_command     <= req.command;
    in_pixel_index <= req.pixel_index;
    in_cur_pixel   <= req.cur_pixel;
    in_prev_pixel  <= req.prev_pixel;
    in_block_row   <= req.block_row;
    in_block_col   <= req.block_col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.accept_request(req);
    burst_left--;
  endtask

  task automatic send_load(input logic [IDX_W-1:0] idx, input logic cur, input logic prev);
    request_t req;
    req.command = CMD_LOAD;
    req.pixel_index = idx;
    req.cur_pixel = cur;
    req.prev_pixel = prev;
    req.block_row = BIDX_W'($urandom_range(0, NBLOCKS - 1));
    req.block_col = BIDX_W'($urandom_range(0, NBLOCKS - 1));
    send_item(req);
  endtask

  task automatic send_match(input logic [BIDX_W-1:0] brow, input logic [BIDX_W-1:0] bcol);
    request_t req;
    req.command = CMD_MATCH;
    req.pixel_index = IDX_W'($urandom_range(0, NPIX - 1));
    req.cur_pixel = 1'($urandom_range(0, 1));
    req.prev_pixel = 1'($urandom_range(0, 1));
    req.block_row = brow;
    req.block_col = bcol;
    send_item(req);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_rows.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic change_radius(input logic [RAD_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.radius = value;
  endtask

  // mostly: nudge one candidate block toward the target, then match the target
  task automatic run_sequences(input int count);
    int left;
    int kind;
    int nloads;
    int tr;
    int tc;
    int cr;
    int cc;
    int k;
    int l;
    int rad;
    int t_idx;
    int c_idx;
    left = count;
    rad = int'(sb.radius);
    tr = pick_block(rad);
    tc = pick_block(rad);
    cr = tr;
    cc = tc;
    while (left > 0) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        send_load(IDX_W'($urandom_range(0, NPIX - 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        left--;
      end else if (kind == 1) begin
        send_match(BIDX_W'(pick_block(rad)), BIDX_W'(pick_block(rad)));
        left--;
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          tr = pick_block(rad);
          tc = pick_block(rad);
          cr = tr + int'($urandom_range(0, 2 * rad)) - rad;
          cc = tc + int'($urandom_range(0, 2 * rad)) - rad;
          if (cr < 0 || cr >= FILL_BLOCKS) cr = tr;
          if (cc < 0 || cc >= FILL_BLOCKS) cc = tc;
        end
        nloads = $urandom_range(1, 12);
        for (int n = 0; n < nloads && left > 1; n++) begin
          k = $urandom_range(0, BLOCK_SIZE - 1);
          l = $urandom_range(0, BLOCK_SIZE - 1);
          t_idx = (tr * BLOCK_SIZE + k) * FRAME_SIZE + tc * BLOCK_SIZE + l;
          c_idx = (cr * BLOCK_SIZE + k) * FRAME_SIZE + cc * BLOCK_SIZE + l;
          if ($urandom_range(0, 3) == 0) begin
            send_load(IDX_W'(t_idx), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          end else begin
            send_load(IDX_W'(c_idx), 1'($urandom_range(0, 1)),
                      sb.cur_frame[t_idx] ^ ($urandom_range(0, 7) == 0));
          end
          left--;
        end
        send_match(BIDX_W'(tr), BIDX_W'(tc));
        left--;
      end
    end
  endtask

  initial begin
    int br;
    int bc;
    int row;
    int col;
    logic c;
    logic p;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_LOAD;
    in_pixel_index = '0;
    in_cur_pixel = 1'b0;
    in_prev_pixel = 1'b0;
    in_block_row = '0;
    in_block_col = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    burst_left = 0;
    max_gap = 1;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // fill the corner blocks; some get all-differ and all-equal content
    for (int i = 0; i < FILL_PIX * FILL_PIX; i++) begin
      row = i / FILL_PIX;
      col = i % FILL_PIX;
      br = row / BLOCK_SIZE;
      bc = col / BLOCK_SIZE;
      c = 1'($urandom_range(0, 1));
      p = 1'($urandom_range(0, 1));
      if (br == 0 && bc == 0) begin
        c = 1'b1;
        p = 1'b0;
      end else if (br == FILL_BLOCKS - 1 && bc == FILL_BLOCKS - 1) begin
        c = 1'b0;
        p = 1'b1;
      end else if (br == 0 && bc == FILL_BLOCKS - 1) begin
        p = c;
      end
      send_load(IDX_W'(row * FRAME_SIZE + col), c, p);
    end

    max_gap = 6;
    send_match(BIDX_W'(0), BIDX_W'(0));
    send_load(IDX_W'(0), 1'b0, 1'b1);
    send_load(IDX_W'(FRAME_SIZE + 1), 1'b1, 1'b1);
    send_match(BIDX_W'(0), BIDX_W'(0));

    change_radius(RAD_W'(0));
    send_match(BIDX_W'(0), BIDX_W'(0));
    send_match(BIDX_W'(0), BIDX_W'(1));
    send_match(BIDX_W'(1), BIDX_W'(0));
    send_match(BIDX_W'(1), BIDX_W'(1));
    run_sequences(24);

    change_radius(RAD_W'(1));
    run_sequences(24);
    change_radius(RAD_W'(0));
    run_sequences(16);

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.expected_rows.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
